### hdl/order_queue_residual_tracker_assert.svh
// assertion macros shared by the order queue residual tracker
`ifndef ORDER_QUEUE_RESIDUAL_TRACKER_ASSERT_SVH
`define ORDER_QUEUE_RESIDUAL_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define OQRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent must hold in the cycle after the trigger
`define OQRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define OQRT_ASSERT(lbl, prop, msg)
`define OQRT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/oqrt_pkg.sv
// shared constants, types and codes of the order queue residual tracker
package oqrt_pkg;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 24;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned SRC_W  = 6;
  localparam int unsigned SIZE_W = 48;
  localparam int unsigned TIME_W = 40;
  localparam int unsigned POS_W  = 6;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  // operation codes
  localparam logic OP_CHANGE = 1'b0;
  localparam logic OP_SEED   = 1'b1;

  // one resting block
  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] born;
  } entry_t;

  // what a cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_HEAD,
    CELL_LOAD
  } cell_cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EAT,
    ST_EMIT
  } state_e;

endpackage

### hdl/oqrt_stream_if.sv
// request and result channel interfaces of the order queue residual tracker
interface oqrt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [oqrt_pkg::SRC_W-1:0]   source_id;
  logic [oqrt_pkg::SIZE_W-1:0]  new_size;
  logic [oqrt_pkg::SIZE_W-1:0]  old_size;
  logic [oqrt_pkg::TIME_W-1:0]  now_time;

  modport source (
    output valid, operation, source_id, new_size, old_size, now_time,
    input  ready
  );
  modport sink (
    input  valid, operation, source_id, new_size, old_size, now_time,
    output ready
  );
endinterface

interface oqrt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_res;
  logic [oqrt_pkg::POS_W-1:0]   position;
  logic [oqrt_pkg::SRC_W-1:0]   block_source;
  logic [oqrt_pkg::SIZE_W-1:0]  block_size;
  logic [oqrt_pkg::TIME_W-1:0]  block_born;
  logic                         last;

  modport source (
    output valid, valid_res, position, block_source, block_size, block_born, last,
    input  ready
  );
  modport sink (
    input  valid, valid_res, position, block_source, block_size, block_born, last,
    output ready
  );
endinterface

### hdl/order_queue_residual_tracker.sv
// top level: row of queue cells with its sequencing controller
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  req_i    | in  | valid / ready | operation, source_id, new_size, old_size, now_time
//  res_o    | out | valid / ready | valid_res, position, block_source, block_size,
//           |     |               | block_born, last
//
// one request at a time: it is taken, then for a decrease the blocks removed at the head go
// one per step, plus a final head compare and subtract step, then max(1, blocks) results
// follow, each a rotation of the cell row
// reset empties the queue at once; cell contents are not cleared
// a stalled result holds the row; no request is taken until the last result goes

`include "order_queue_residual_tracker_assert.svh"

module order_queue_residual_tracker (
  input logic        clk_i,
  input logic        rst_ni,
  oqrt_in_if.sink    req_i,
  oqrt_out_if.source res_o
);

  localparam int unsigned D = oqrt_pkg::QUEUE_DEPTH;

  oqrt_pkg::state_e                 st_q, st_d;
  logic [oqrt_pkg::CNT_W-1:0]       count_q, count_d;
  logic [oqrt_pkg::SIZE_W-1:0]      need_q, need_d;
  logic [oqrt_pkg::IDX_W-1:0]       idx_q, idx_d;

  oqrt_pkg::cell_cmd_e              cmd   [D];
  oqrt_pkg::entry_t                 ent   [D];
  oqrt_pkg::entry_t                 load_ent;
  oqrt_pkg::entry_t                 head, tail;

  logic                             req_fire, res_fire;
  logic                             is_up, is_down, full;
  logic [oqrt_pkg::SIZE_W-1:0]      up_amt, down_amt;
  logic [oqrt_pkg::SIZE_W:0]        merge_sum;
  logic [oqrt_pkg::SIZE_W-1:0]      merge_size;
  logic [oqrt_pkg::TIME_W-1:0]      merge_born;
  logic                             eat_go, head_eaten, last_res;

  // the row of cells, a ring; a rotation brings the head round to the last occupied cell
  for (genvar i = 0; i < D; i++) begin : g_cell
    oqrt_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd[i]),
      .next_i (ent[(i + 1) % D]),
      .head_i (ent[0]),
      .load_i (load_ent),
      .ent_o  (ent[i])
    );
  end

  assign head = ent[0];
  assign tail = ent[D-1];

  // handshakes and request decode
  assign req_fire = req_i.valid && req_i.ready;
  assign res_fire = res_o.valid && res_o.ready;
  assign is_up    = req_i.new_size > req_i.old_size;
  assign is_down  = req_i.new_size < req_i.old_size;
  assign up_amt   = req_i.new_size - req_i.old_size;
  assign down_amt = req_i.old_size - req_i.new_size;
  assign full     = count_q == oqrt_pkg::CNT_W'(D);

  // overflow merge into the tail block, size saturates
  assign merge_sum  = {1'b0, tail.size} + {1'b0, up_amt};
  assign merge_size = merge_sum[oqrt_pkg::SIZE_W] ? oqrt_pkg::SIZE_MAX
                                                  : merge_sum[oqrt_pkg::SIZE_W-1:0];
  assign merge_born = ((tail.born != '0) &&
                       ((req_i.now_time == '0) || (req_i.now_time < tail.born)))
                      ? req_i.now_time : tail.born;

  // head consumption and read-out status
  assign eat_go     = (need_q != '0) && (count_q != '0);
  assign head_eaten = head.size <= need_q;
  assign last_res   = (count_q == '0) ||
                      ((oqrt_pkg::CNT_W'(idx_q) + 1'b1) == count_q);

  // next state
  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    need_d  = need_q;
    idx_d   = idx_q;
    case (st_q)
      oqrt_pkg::ST_IDLE: begin
        if (req_fire) begin
          idx_d = '0;
          st_d  = oqrt_pkg::ST_EMIT;
          if (req_i.operation == oqrt_pkg::OP_SEED) begin
            count_d = oqrt_pkg::CNT_W'(1);
          end else if (is_down) begin
            need_d = down_amt;
            st_d   = oqrt_pkg::ST_EAT;
          end else if (is_up && !full) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      oqrt_pkg::ST_EAT: begin
        if (!eat_go) begin
          st_d = oqrt_pkg::ST_EMIT;
        end else if (head_eaten) begin
          need_d  = need_q - head.size;
          count_d = count_q - 1'b1;
        end else begin
          need_d = '0;
          st_d   = oqrt_pkg::ST_EMIT;
        end
      end
      oqrt_pkg::ST_EMIT: begin
        if (res_fire) begin
          if (last_res) begin
            idx_d = '0;
            st_d  = oqrt_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: st_d = oqrt_pkg::ST_IDLE;
    endcase
  end

  // cell commands, load data and channel outputs
  always_comb begin
    req_i.ready = st_q == oqrt_pkg::ST_IDLE;
    res_o.valid = st_q == oqrt_pkg::ST_EMIT;
    load_ent    = head;
    for (int i = 0; i < D; i++) begin
      cmd[i] = oqrt_pkg::CELL_HOLD;
    end
    case (st_q)
      oqrt_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req_i.operation == oqrt_pkg::OP_SEED) begin
            cmd[0]   = oqrt_pkg::CELL_LOAD;
            load_ent = '{src: req_i.source_id, size: req_i.new_size, born: '0};
          end else if (is_up && full) begin
            cmd[D-1] = oqrt_pkg::CELL_LOAD;
            load_ent = '{src: tail.src, size: merge_size, born: merge_born};
          end else if (is_up) begin
            load_ent = '{src: req_i.source_id, size: up_amt, born: req_i.now_time};
            for (int i = 0; i < D; i++) begin
              if (count_q == oqrt_pkg::CNT_W'(i)) begin
                cmd[i] = oqrt_pkg::CELL_LOAD;
              end
            end
          end
        end
      end
      oqrt_pkg::ST_EAT: begin
        if (eat_go) begin
          if (head_eaten) begin
            for (int i = 0; i < D; i++) begin
              cmd[i] = oqrt_pkg::CELL_SHIFT;
            end
          end else begin
            cmd[0]   = oqrt_pkg::CELL_LOAD;
            load_ent = '{src: head.src, size: head.size - need_q, born: head.born};
          end
        end
      end
      oqrt_pkg::ST_EMIT: begin
        // rotate the occupied part of the row by one block
        if (res_fire && (count_q != '0)) begin
          for (int i = 0; i < D; i++) begin
            if ((oqrt_pkg::CNT_W'(i) + 1'b1) == count_q) begin
              cmd[i] = oqrt_pkg::CELL_HEAD;
            end else if ((oqrt_pkg::CNT_W'(i) + 1'b1) < count_q) begin
              cmd[i] = oqrt_pkg::CELL_SHIFT;
            end
          end
        end
      end
      default: ;
    endcase

    // result payload, all zero but last for an empty queue
    res_o.last = last_res;
    if (count_q == '0) begin
      res_o.valid_res    = 1'b0;
      res_o.position     = '0;
      res_o.block_source = '0;
      res_o.block_size   = '0;
      res_o.block_born   = '0;
    end else begin
      res_o.valid_res    = 1'b1;
      res_o.position     = oqrt_pkg::POS_W'(idx_q);
      res_o.block_source = head.src;
      res_o.block_size   = head.size;
      res_o.block_born   = head.born;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= oqrt_pkg::ST_IDLE;
      count_q <= '0;
      need_q  <= '0;
      idx_q   <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      need_q  <= need_d;
      idx_q   <= idx_d;
    end
  end

  // checks
  `OQRT_ASSERT(a_count_bound, count_q <= oqrt_pkg::CNT_W'(D), "queue count above depth")
  `OQRT_ASSERT(a_one_side, !(req_i.ready && res_o.valid), "request taken during read-out")
  `OQRT_ASSERT_NEXT(a_eat_step, st_q == oqrt_pkg::ST_EAT, (count_q == $past(count_q)) || (count_q == $past(count_q) - 1'b1), "more than one block removed in a cycle")
  `OQRT_ASSERT_NEXT(a_last_idle, res_fire && res_o.last, st_q == oqrt_pkg::ST_IDLE, "no return to idle after final result")

endmodule

### hdl/oqrt_cell.sv
// one queue cell: holds a block and takes it from its neighbour, the head or a load
module oqrt_cell (
  input  logic                clk_i,
  input  oqrt_pkg::cell_cmd_e cmd_i,
  input  oqrt_pkg::entry_t    next_i,
  input  oqrt_pkg::entry_t    head_i,
  input  oqrt_pkg::entry_t    load_i,
  output oqrt_pkg::entry_t    ent_o
);

  oqrt_pkg::entry_t ent_q, ent_d;

  // select the incoming block
  always_comb begin
    case (cmd_i)
      oqrt_pkg::CELL_HOLD:  ent_d = ent_q;
      oqrt_pkg::CELL_SHIFT: ent_d = next_i;
      oqrt_pkg::CELL_HEAD:  ent_d = head_i;
      oqrt_pkg::CELL_LOAD:  ent_d = load_i;
      default:              ent_d = ent_q;
    endcase
  end

  // block storage, no reset needed
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule
